FILE: rtl/ascii_decimal_frame_builder_top_assert.svh
// Assertion macros used by the frame builder controller.
`ifndef ASCII_DECIMAL_FRAME_BUILDER_TOP_ASSERT_SVH
`define ASCII_DECIMAL_FRAME_BUILDER_TOP_ASSERT_SVH
`ifndef SYNTH
`define ADFB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ADFB_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ADFB_ASSERT(lbl, clk, rst, prop, msg)
`define ADFB_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: rtl/adfb_pkg.sv
// Shared constants, types and character functions of the frame builder.
`default_nettype none
package adfb_pkg;

   localparam int PosWidth = 5;

   localparam logic [7:0] CharStx      = 8'h02;
   localparam logic [7:0] CharEtx      = 8'h03;
   localparam logic [7:0] CharB        = 8'h62;
   localparam logic [7:0] CharA        = 8'h61;
   localparam logic [7:0] CharOpen     = 8'h5B;
   localparam logic [7:0] CharClose    = 8'h5D;
   localparam logic [7:0] CharComma    = 8'h2C;
   localparam logic [7:0] CharZero     = 8'h30;
   localparam logic [7:0] CharHexBase  = 8'h37;

   localparam logic [2:0] CountMin = 3'd2;
   localparam logic [2:0] CountMax = 3'd4;

   typedef logic [PosWidth-1:0] pos_type;

   localparam pos_type PosStx        = 5'd0;
   localparam pos_type PosB          = 5'd1;
   localparam pos_type PosA          = 5'd2;
   localparam pos_type PosCmd        = 5'd3;
   localparam pos_type PosOpen       = 5'd4;
   localparam pos_type PosFirstDigit = 5'd5;
   localparam pos_type PosTailBase   = 5'd7;

   localparam logic [1:0] DigitHundreds = 2'd0;
   localparam logic [1:0] DigitTens     = 2'd1;
   localparam logic [1:0] DigitUnits    = 2'd2;
   localparam logic [1:0] DigitComma    = 2'd3;

   typedef struct packed {
      logic    load;
      logic    emit;
      pos_type pos;
   } ctl_cmd_type;

   typedef struct packed {
      logic    slot_free;
      pos_type last_pos;
   } ctl_sts_type;

   function automatic logic [7:0] digit_char(input logic [7:0] value, input logic [1:0] sel);
      logic [1:0]  hund;
      logic [6:0]  rem;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  units;
      logic [7:0]  res;
      if (value >= 8'd200) begin
         hund = 2'd2;
         rem  = 7'(value - 8'd200);
      end else if (value >= 8'd100) begin
         hund = 2'd1;
         rem  = 7'(value - 8'd100);
      end else begin
         hund = 2'd0;
         rem  = value[6:0];
      end
      prod  = 15'(rem * 8'd205);
      tens  = prod[14:11];
      units = 7'(rem - 7'({3'b000, tens} * 7'd10));
      case (sel)
         DigitHundreds: res = CharZero + {6'b000000, hund};
         DigitTens:     res = CharZero + {4'b0000, tens};
         default:       res = CharZero + {1'b0, units};
      endcase
      return res;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CharZero + {4'b0000, nib};
      end
      return CharHexBase + {4'b0000, nib};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/adfb_datapath.sv
// Frame builder datapath: item capture, byte selection, checksum and output register.
`default_nettype none
module adfb_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [47:0]               req_tdata,
   input  wire adfb_pkg::ctl_cmd_type     cmd,
   output adfb_pkg::ctl_sts_type          sts,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast
);
   import adfb_pkg::*;

   logic [7:0]      cmd_code_ff, cmd_code_in;
   logic [2:0]      count_ff, count_in;
   logic [3:0][7:0] vals_ff, vals_in;
   logic [7:0]      csum_ff, csum_in;
   logic            valid_ff, valid_in;
   logic [7:0]      byte_ff, byte_in;
   logic            last_ff, last_in;

   pos_type    last_pos, close_pos, hi_pos, lo_pos, off;
   logic [7:0] sel_byte;
   logic [2:0] raw_count;

   assign raw_count = req_tdata[10:8];
   assign last_pos  = PosTailBase + {count_ff, 2'b00};
   assign close_pos = last_pos - 5'd3;
   assign hi_pos    = last_pos - 5'd2;
   assign lo_pos    = last_pos - 5'd1;
   assign off       = cmd.pos - PosFirstDigit;

   always_comb begin
      if (cmd.pos == PosStx) begin
         sel_byte = CharStx;
      end else if (cmd.pos == PosB) begin
         sel_byte = CharB;
      end else if (cmd.pos == PosA) begin
         sel_byte = CharA;
      end else if (cmd.pos == PosCmd) begin
         sel_byte = cmd_code_ff;
      end else if (cmd.pos == PosOpen) begin
         sel_byte = CharOpen;
      end else if (cmd.pos == close_pos) begin
         sel_byte = CharClose;
      end else if (cmd.pos == hi_pos) begin
         sel_byte = hex_char(csum_ff[7:4]);
      end else if (cmd.pos == lo_pos) begin
         sel_byte = hex_char(csum_ff[3:0]);
      end else if (cmd.pos == last_pos) begin
         sel_byte = CharEtx;
      end else if (off[1:0] == DigitComma) begin
         sel_byte = CharComma;
      end else begin
         sel_byte = digit_char(vals_ff[off[3:2]], off[1:0]);
      end
   end

   always_comb begin
      cmd_code_in = cmd_code_ff;
      count_in    = count_ff;
      vals_in     = vals_ff;
      csum_in     = csum_ff;
      valid_in    = valid_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      if (cmd.load) begin
         cmd_code_in = req_tdata[7:0];
         if (raw_count < CountMin) begin
            count_in = CountMin;
         end else if (raw_count > CountMax) begin
            count_in = CountMax;
         end else begin
            count_in = raw_count;
         end
         vals_in = req_tdata[42:11];
         csum_in = 8'h00;
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         last_in  = (cmd.pos == last_pos);
         if ((cmd.pos != PosStx) && (cmd.pos <= close_pos)) begin
            csum_in = csum_ff ^ sel_byte;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_code_ff <= cmd_code_in;
      count_ff    <= count_in;
      vals_ff     <= vals_in;
      csum_ff     <= csum_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
   end

   assign sts.slot_free = !valid_ff || rsp_tready;
   assign sts.last_pos  = last_pos;
   assign rsp_tvalid    = valid_ff;
   assign rsp_tdata     = byte_ff;
   assign rsp_tlast     = last_ff;

endmodule
`default_nettype wire

FILE: rtl/adfb_controller.sv
// Frame builder controller: accepts items and steps through the frame positions.
`default_nettype none
`include "ascii_decimal_frame_builder_top_assert.svh"
module adfb_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire adfb_pkg::ctl_sts_type sts,
   output adfb_pkg::ctl_cmd_type      cmd
);
   import adfb_pkg::*;

   localparam logic StIdle = 1'b0;
   localparam logic StSend = 1'b1;

   logic    state_ff, state_in;
   pos_type pos_ff, pos_in;

   always_comb begin
      cmd.load = 1'b0;
      cmd.emit = 1'b0;
      cmd.pos  = pos_ff;
      state_in = state_ff;
      pos_in   = pos_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = StSend;
               pos_in   = PosStx;
            end
         end
         StSend: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               if (pos_ff == sts.last_pos) begin
                  state_in = StIdle;
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         pos_ff   <= PosStx;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   assign req_tready = (state_ff == StIdle);

   `ADFB_ASSERT(a_pos_in_frame, clock, reset, (state_ff == StSend) |-> (pos_ff <= sts.last_pos), "position past frame end")
   `ADFB_ASSERT(a_load_starts, clock, reset, cmd.load |=> (state_ff == StSend && pos_ff == PosStx), "load did not start frame")
   `ADFB_ASSERT(a_end_idles, clock, reset, (cmd.emit && pos_ff == sts.last_pos) |=> (state_ff == StIdle), "frame end did not idle")
   `ADFB_ASSERT_NEVER(a_no_overlap, clock, reset, cmd.load && cmd.emit, "load during emit")

endmodule
`default_nettype wire

FILE: rtl/ascii_decimal_frame_builder_top.sv
// Top level of the ASCII decimal frame builder.
//
//   channel  direction  tdata                                 tuser  tlast
//   req      in         command, count, four values (48 bit)  -      -
//   rsp      out        frame byte (8 bit)                    -      last_byte
//
// One request transaction yields a frame of 16, 20 or 24 response transactions.
// The output register sends one byte per cycle while the receiver is ready; the
// controller accepts an item only while idle, then steps through every frame byte.
// A stalled response holds the byte and the frame sequencer waits.
// Reset is synchronous and clears the sequencer and the output valid.
`default_nettype none
module ascii_decimal_frame_builder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command_code[7:0], value_count[10:8], first_value[18:11], second_value[26:19],
   // third_value[34:27], fourth_value[42:35], zero fill [47:43]
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // frame_byte[7:0]
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);
   import adfb_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   adfb_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   adfb_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: test/adfb_frame_checker.sv
// Frame builder checker: predicts every frame byte from the requests and compares the responses.
`default_nettype none
module adfb_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        rsp_tlast,
   output int               error_count,
   output int               bytes_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import adfb_pkg::*;

   localparam logic [7:0] CharUpperA = 8'h41;

   typedef struct packed {
      logic [7:0] frame_char;
      logic       is_last;
   } frame_entry_type;

   frame_entry_type awaited_bytes[$];
   logic [7:0]      frame_xor;
   int              mismatches = 0;

   function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CharZero + {4'b0000, nib};
      end
      return CharUpperA + {4'b0000, nib - 4'd10};
   endfunction

   task automatic add_plain(input logic [7:0] c, input logic last);
      awaited_bytes.push_back('{frame_char: c, is_last: last});
   endtask

   task automatic add_summed(input logic [7:0] c);
      add_plain(c, 1'b0);
      frame_xor = frame_xor ^ c;
   endtask

   task automatic predict_frame(input logic [47:0] item);
      logic [7:0] vals [4];
      logic [2:0] raw_count;
      int         count;
      raw_count = item[10:8];
      vals[0]   = item[18:11];
      vals[1]   = item[26:19];
      vals[2]   = item[34:27];
      vals[3]   = item[42:35];
      if (raw_count < CountMin) begin
         count = int'(CountMin);
      end else if (raw_count > CountMax) begin
         count = int'(CountMax);
      end else begin
         count = int'(raw_count);
      end
      frame_xor = 8'h00;
      add_plain(CharStx, 1'b0);
      add_summed(CharB);
      add_summed(CharA);
      add_summed(item[7:0]);
      add_summed(CharOpen);
      for (int i = 0; i < count; i++) begin
         if (i != 0) begin
            add_summed(CharComma);
         end
         add_summed(CharZero + vals[2'(i)] / 8'd100);
         add_summed(CharZero + (vals[2'(i)] % 8'd100) / 8'd10);
         add_summed(CharZero + vals[2'(i)] % 8'd10);
      end
      add_summed(CharClose);
      add_plain(nibble_ascii(frame_xor[7:4]), 1'b0);
      add_plain(nibble_ascii(frame_xor[3:0]), 1'b0);
      add_plain(CharEtx, 1'b1);
   endtask

   always @(posedge clock) begin
      frame_entry_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_frame(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_bytes.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected frame byte: expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = awaited_bytes.pop_front();
               if (want.frame_char !== rsp_tdata || want.is_last !== rsp_tlast) begin
                  mismatches++;
                  $display("%0t: frame byte mismatch: expected %h last %b, actual %h last %b",
                           $time, want.frame_char, want.is_last, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
      error_count       <= mismatches;
      bytes_outstanding <= awaited_bytes.size();
   end

endmodule
`default_nettype wire

FILE: test/tb_ascii_decimal_frame_builder_top.sv
// Testbench top: drives frame requests with bursty timing and a stalling receiver.
`default_nettype none
module tb_ascii_decimal_frame_builder_top;
   timeunit 1ns;
   timeprecision 1ps;
   import adfb_pkg::*;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   int          error_count;
   int          bytes_outstanding;

   int burst_left = 0;
   int ready_mode = 0;
   int mode_left  = 0;

   always #1 clock = ~clock;

   ascii_decimal_frame_builder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   adfb_frame_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .error_count       (error_count),
      .bytes_outstanding (bytes_outstanding)
   );

   function automatic logic [47:0] pack_request(input logic [7:0] cmd, input logic [2:0] cnt,
                                                input logic [7:0] v0, input logic [7:0] v1,
                                                input logic [7:0] v2, input logic [7:0] v3);
      return {5'b00000, v3, v2, v1, v0, cnt, cmd};
   endfunction

   function automatic logic [7:0] pick_value();
      logic [7:0] edges [8] = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd199, 8'd200, 8'd255};
      if ($urandom_range(0, 3) == 0) begin
         return edges[3'($urandom_range(0, 7))];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic offer_request(input logic [47:0] item);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
   endtask

   // receiver stall pattern: phases of full rate, light, heavy and sparse stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (ready_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   initial begin
      #1ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      offer_request(pack_request(8'h00, 3'd2, 8'd0, 8'd0, 8'hAA, 8'h55));
      offer_request(pack_request(8'hFF, 3'd2, 8'd255, 8'd255, 8'h00, 8'hFF));
      offer_request(pack_request(8'h78, 3'd3, 8'd100, 8'd199, 8'd200, 8'hFF));
      offer_request(pack_request(8'h41, 3'd4, 8'd9, 8'd10, 8'd99, 8'd255));
      offer_request(pack_request(8'h80, 3'd4, 8'd255, 8'd255, 8'd255, 8'd255));
      offer_request(pack_request(8'h7F, 3'd4, 8'd0, 8'd0, 8'd0, 8'd0));
      offer_request(pack_request(8'h01, 3'd0, 8'd1, 8'd2, 8'd3, 8'd4));
      offer_request(pack_request(8'h02, 3'd1, 8'd128, 8'd127, 8'd64, 8'd32));
      offer_request(pack_request(8'h55, 3'd5, 8'd11, 8'd22, 8'd33, 8'd44));
      offer_request(pack_request(8'hAA, 3'd6, 8'd55, 8'd66, 8'd77, 8'd88));
      offer_request(pack_request(8'h5A, 3'd7, 8'd101, 8'd202, 8'd250, 8'd5));
      offer_request(pack_request(8'hA5, 3'd3, 8'd1, 8'd90, 8'd254, 8'hFF));
      offer_request(pack_request(8'h30, 3'd2, 8'd19, 8'd91, 8'hFF, 8'hFF));
      offer_request(pack_request(8'h62, 3'd4, 8'd200, 8'd100, 8'd10, 8'd1));

      for (int n = 0; n < 260; n++) begin
         logic [2:0] cnt;
         cnt = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(2, 4)) : 3'($urandom_range(0, 7));
         offer_request(pack_request(8'($urandom_range(0, 255)), cnt, pick_value(),
                                    pick_value(), pick_value(), pick_value()));
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (bytes_outstanding != 0);
      repeat (40) @(posedge clock);

      if (error_count == 0 && bytes_outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/adfb_pkg.sv
rtl/adfb_datapath.sv
rtl/adfb_controller.sv
rtl/ascii_decimal_frame_builder_top.sv
test/adfb_frame_checker.sv
test/tb_ascii_decimal_frame_builder_top.sv
